[src/ipav_pkg.sv]
// Shared types, character codes and helper functions for the IP address text validator.
package ipav_pkg;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_V4   = 2'd1,
		KIND_V6   = 2'd2
	} kind_t;

	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CASE_MASK = 8'hDF;

	localparam logic [11:0] OCTET_MAX    = 12'd255;
	localparam logic [1:0]  OCTET_DIGITS = 2'd3;
	localparam logic [1:0]  DOTS_NEEDED  = 2'd3;
	localparam logic [2:0]  GROUP_DIGITS = 3'd4;
	localparam logic [3:0]  COLONS_FULL  = 4'd7;
	localparam logic [3:0]  COLONS_MIN   = 4'd2;
	localparam logic [3:0]  COLONS_SAT   = 4'd8;

	function automatic logic [3:0] add_colons(input logic [3:0] cnt, input logic [1:0] n);
		logic [4:0] sum;
		sum = {1'b0, cnt} + {3'b000, n};
		return (sum > {1'b0, COLONS_SAT}) ? COLONS_SAT : sum[3:0];
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		logic [7:0] u;
		u = c & CASE_MASK;
		return is_digit(c) || ((u >= CH_UPPER_A) && (u <= CH_UPPER_F));
	endfunction

endpackage

[src/ipav_if.sv]
// Valid/ready channel interfaces for the character stream and the verdict stream.
interface ipav_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ipav_verdict_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;

	modport source (output valid, output kind, input ready);
	modport sink   (input valid, input kind, output ready);
endinterface

[src/ip_address_text_validator_core.sv]
// Streaming IPv4 / IPv6 address text validator: one character per request, verdict on last.
//
// Characters of one address string arrive one per request, the final one flagged by last.
// An IPv4 dotted-quad checker and an IPv6 checker run side by side; on the last character
// one verdict goes out: 0 not an address, 1 IPv4, 2 IPv6. The block takes one character
// every cycle unless stalled; a verdict passes the input register and the combinational
// checker update, which feeds the verdict register.
// Input stalls only while a verdict is waiting and the next last character needs the slot.
module ip_address_text_validator_core
	import ipav_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	ipav_text_if.sink             text,
	ipav_verdict_if.source        verdict
);

	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic        last_s1;
	logic        adv_s1;

	logic        v4_fail_q;
	logic [1:0]  v4_dots_q;
	logic [7:0]  v4_val_q;
	logic [1:0]  v4_digits_q;
	logic        v4_lz_q;
	logic        v6_fail_q;
	logic [3:0]  v6_colons_q;
	logic [2:0]  v6_group_q;
	logic        v6_double_q;
	logic        v6_pend_q;

	logic        v4_fail_d;
	logic [1:0]  v4_dots_d;
	logic [7:0]  v4_val_d;
	logic [1:0]  v4_digits_d;
	logic        v4_lz_d;
	logic        v6_fail_d;
	logic [3:0]  v6_colons_d;
	logic [2:0]  v6_group_d;
	logic        v6_double_d;
	logic        v6_pend_d;

	logic        out_valid_q;
	kind_t       kind_q;
	kind_t       kind_d;

	logic [11:0] nv;
	logic [3:0]  dval;
	logic        v4_ok;
	logic        v6_ok;
	logic        v6_done;

	assign adv_s1      = valid_s1 && (!last_s1 || !out_valid_q || verdict.ready);
	assign text.ready  = !valid_s1 || adv_s1;
	assign verdict.valid = out_valid_q;
	assign verdict.kind  = kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			ch_s1   <= text.ch;
			last_s1 <= text.last;
		end
	end

	// IPv4 checker update
	always_comb begin
		dval        = ch_s1[3:0] - CH_ZERO[3:0];
		nv          = ({4'd0, v4_val_q} << 3) + ({4'd0, v4_val_q} << 1) + {8'd0, dval};
		v4_fail_d   = v4_fail_q;
		v4_dots_d   = v4_dots_q;
		v4_val_d    = v4_val_q;
		v4_digits_d = v4_digits_q;
		v4_lz_d     = v4_lz_q;
		if (!v4_fail_q) begin
			if (ch_s1 == CH_DOT) begin
				if (v4_digits_q == 2'd0 || (v4_lz_q && v4_digits_q > 2'd1) ||
						v4_dots_q == DOTS_NEEDED) begin
					v4_fail_d = 1'b1;
				end else begin
					v4_dots_d   = v4_dots_q + 2'd1;
					v4_val_d    = 8'd0;
					v4_digits_d = 2'd0;
					v4_lz_d     = 1'b0;
				end
			end else if (is_digit(ch_s1)) begin
				if (v4_digits_q == OCTET_DIGITS || nv > OCTET_MAX) begin
					v4_fail_d = 1'b1;
				end else begin
					if (v4_digits_q == 2'd0) begin
						v4_lz_d = (dval == 4'd0);
					end
					v4_digits_d = v4_digits_q + 2'd1;
					v4_val_d    = nv[7:0];
				end
			end else begin
				v4_fail_d = 1'b1;
			end
		end
	end

	// IPv6 checker update; a single colon waits one character
	always_comb begin
		v6_fail_d   = v6_fail_q;
		v6_colons_d = v6_colons_q;
		v6_group_d  = v6_group_q;
		v6_double_d = v6_double_q;
		v6_pend_d   = v6_pend_q;
		v6_done     = 1'b0;
		if (!v6_fail_q) begin
			if (v6_pend_q) begin
				v6_pend_d = 1'b0;
				if (ch_s1 == CH_COLON) begin
					v6_done = 1'b1;
					if (v6_double_q) begin
						v6_fail_d = 1'b1;
					end else begin
						v6_double_d = 1'b1;
						v6_colons_d = add_colons(v6_colons_q, 2'd2);
						v6_group_d  = 3'd0;
					end
				end else begin
					v6_colons_d = add_colons(v6_colons_q, 2'd1);
					v6_group_d  = 3'd0;
				end
			end
			if (!v6_done) begin
				if (ch_s1 == CH_COLON) begin
					if (last_s1) begin
						if (!v6_double_d) begin
							v6_fail_d = 1'b1;
						end else begin
							v6_colons_d = add_colons(v6_colons_d, 2'd1);
							v6_group_d  = 3'd0;
						end
					end else begin
						v6_pend_d = 1'b1;
					end
				end else if (!is_hex(ch_s1) || v6_group_d >= GROUP_DIGITS) begin
					v6_fail_d = 1'b1;
				end else begin
					v6_group_d = v6_group_d + 3'd1;
				end
			end
		end
	end

	always_comb begin
		v4_ok = !v4_fail_d && v4_dots_d == DOTS_NEEDED && v4_digits_d != 2'd0 &&
			!(v4_lz_d && v4_digits_d > 2'd1);
		v6_ok = !v6_fail_d && !v6_pend_d && v6_colons_d >= COLONS_MIN &&
			(v6_double_d ? (v6_colons_d <= COLONS_FULL) : (v6_colons_d == COLONS_FULL));
		kind_d = v4_ok ? KIND_V4 : (v6_ok ? KIND_V6 : KIND_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_fail_q   <= 1'b0;
			v4_dots_q   <= 2'd0;
			v4_val_q    <= 8'd0;
			v4_digits_q <= 2'd0;
			v4_lz_q     <= 1'b0;
			v6_fail_q   <= 1'b0;
			v6_colons_q <= 4'd0;
			v6_group_q  <= 3'd0;
			v6_double_q <= 1'b0;
			v6_pend_q   <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				v4_fail_q   <= 1'b0;
				v4_dots_q   <= 2'd0;
				v4_val_q    <= 8'd0;
				v4_digits_q <= 2'd0;
				v4_lz_q     <= 1'b0;
				v6_fail_q   <= 1'b0;
				v6_colons_q <= 4'd0;
				v6_group_q  <= 3'd0;
				v6_double_q <= 1'b0;
				v6_pend_q   <= 1'b0;
			end else begin
				v4_fail_q   <= v4_fail_d;
				v4_dots_q   <= v4_dots_d;
				v4_val_q    <= v4_val_d;
				v4_digits_q <= v4_digits_d;
				v4_lz_q     <= v4_lz_d;
				v6_fail_q   <= v6_fail_d;
				v6_colons_q <= v6_colons_d;
				v6_group_q  <= v6_group_d;
				v6_double_q <= v6_double_d;
				v6_pend_q   <= v6_pend_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			kind_q <= kind_d;
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> !v4_fail_q && v4_dots_q == 2'd0 && v6_colons_q == 4'd0 &&
			!v6_pend_q && !v6_double_q)
		else $error("checker state not cleared after last character");

	a_verdict_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1 && last_s1))
		else $error("verdict raised without a last character");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |-> !out_valid_q || verdict.ready)
		else $error("pending verdict overwritten");

	a_counter_limits: assert property (@(posedge clk) disable iff (!arst_n)
		v6_colons_q <= COLONS_SAT && v6_group_q <= GROUP_DIGITS)
		else $error("IPv6 counters out of range");

endmodule

[bench/ip_address_text_validator_core_test.sv]
// Self-checking testbench for the IP address text validator: directed table, then random strings.
module ip_address_text_validator_core_test;
	import ipav_pkg::*;

	localparam int PREDICT      = -1;
	localparam int N_DIRECTED   = 25;
	localparam int CHAR_TARGET  = 900;
	localparam int CALM_AFTER   = 780;
	localparam int CHOKE_AT     = 300;
	localparam int CHOKE_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PRINT_LIMIT  = 20;

	typedef logic [7:0] char_q_t[$];

	typedef struct packed {
		logic       v4_bad;
		logic [1:0] dots;
		logic [9:0] oct_val;
		logic [1:0] oct_dig;
		logic       oct_lz;
		logic       v6_bad;
		logic [3:0] colons;
		logic [2:0] grp_dig;
		logic       dbl;
		logic       held;
	} scan_state_t;

	logic clk;
	logic arst_n;

	ipav_text_if    text_bus ();
	ipav_verdict_if verdict_bus ();

	ip_address_text_validator_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_bus),
		.verdict(verdict_bus)
	);

	scan_state_t scan;
	kind_t       verdict_due[$];
	kind_t       next_due;
	int          errors = 0;
	int          cycle_count = 0;
	int          chars_sent = 0;
	int          strings_sent = 0;
	int          stall_cycles = 0;
	int          kind_seen[3] = '{0, 0, 0};
	int          short_left = 0;
	int          choke_left = 0;
	bit          choke_req = 0;
	bit          choke_done = 0;
	bit          calm = 0;

	string dir_text[N_DIRECTED] = '{
		"7", "1.2.3.4", "255.255.255.255", "0.0.0.0", "256.1.1.1",
		"01.2.3.4", "1.2.3.04", "1.2.3.4.5", "1..2.3", "1.2.3.1000",
		"1.2.3.4:", "::", ":::1", ":1:2:3:4:5:6:7", "1:2:3:4:5:6:7:8",
		"1:2:3:4:5:6:7", "1:2:3:4:5:6:7:8:9", "ABCD:ef01::", "fF:0::", "1:2::3:4:",
		"1:2:", "1::2::3", "12345::", "\001", "\377::1"
	};
	int dir_want[N_DIRECTED] = '{
		KIND_NONE, KIND_V4, KIND_V4, KIND_V4, KIND_NONE,
		KIND_NONE, KIND_NONE, KIND_NONE, KIND_NONE, KIND_NONE,
		KIND_NONE, KIND_V6, PREDICT, PREDICT, KIND_V6,
		KIND_NONE, KIND_NONE, PREDICT, PREDICT, PREDICT,
		KIND_NONE, KIND_NONE, KIND_NONE, KIND_NONE, KIND_NONE
	};

	function automatic logic [3:0] colons_plus(input logic [3:0] n, input int add);
		return (n + add > COLONS_SAT) ? COLONS_SAT : 4'(n + add);
	endfunction

	function automatic void scan_char(input logic [7:0] c, input bit fin,
			output bit has, output kind_t verdict_kind);
		int         nv;
		logic [7:0] up;
		bit         is_num;
		bit         is_hexc;
		bit         taken;
		bit         v4_ok;
		bit         v6_ok;
		is_num = (c >= CH_ZERO) && (c <= CH_NINE);
		up = c & CASE_MASK;
		is_hexc = is_num || ((up >= CH_UPPER_A) && (up <= CH_UPPER_F));
		has = 0;
		verdict_kind = KIND_NONE;
		taken = 0;

		if (!scan.v4_bad) begin
			if (c == CH_DOT) begin
				if (scan.oct_dig == 0 || (scan.oct_lz && scan.oct_dig > 1) ||
						scan.dots == DOTS_NEEDED) begin
					scan.v4_bad = 1;
				end else begin
					scan.dots++;
					scan.oct_val = '0;
					scan.oct_dig = '0;
					scan.oct_lz = 0;
				end
			end else if (is_num) begin
				nv = scan.oct_val * 10 + (c - CH_ZERO);
				if (scan.oct_dig == OCTET_DIGITS || nv > OCTET_MAX) begin
					scan.v4_bad = 1;
				end else begin
					if (scan.oct_dig == 0)
						scan.oct_lz = (c == CH_ZERO);
					scan.oct_dig++;
					scan.oct_val = 10'(nv);
				end
			end else begin
				scan.v4_bad = 1;
			end
		end

		if (!scan.v6_bad) begin
			if (scan.held) begin
				scan.held = 0;
				if (c == CH_COLON) begin
					taken = 1;
					if (scan.dbl) begin
						scan.v6_bad = 1;
					end else begin
						scan.dbl = 1;
						scan.colons = colons_plus(scan.colons, 2);
						scan.grp_dig = '0;
					end
				end else begin
					scan.colons = colons_plus(scan.colons, 1);
					scan.grp_dig = '0;
				end
			end
			if (!taken) begin
				if (c == CH_COLON) begin
					if (!fin) begin
						scan.held = 1;
					end else if (!scan.dbl) begin
						scan.v6_bad = 1;
					end else begin
						scan.colons = colons_plus(scan.colons, 1);
						scan.grp_dig = '0;
					end
				end else if (!is_hexc || scan.grp_dig >= GROUP_DIGITS) begin
					scan.v6_bad = 1;
				end else begin
					scan.grp_dig++;
				end
			end
		end

		if (fin) begin
			v4_ok = !scan.v4_bad && scan.dots == DOTS_NEEDED && scan.oct_dig != 0 &&
				!(scan.oct_lz && scan.oct_dig > 1);
			v6_ok = !scan.v6_bad && !scan.held && scan.colons >= COLONS_MIN &&
				(scan.dbl ? scan.colons <= COLONS_FULL : scan.colons == COLONS_FULL);
			has = 1;
			verdict_kind = v4_ok ? KIND_V4 : (v6_ok ? KIND_V6 : KIND_NONE);
			scan = '0;
		end
	endfunction

	function automatic char_q_t text_bytes(input string s);
		char_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	function automatic logic [7:0] pick_from(input string set);
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	function automatic char_q_t v4_text();
		string s;
		int    octets;
		int    v;
		s = "";
		octets = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 5) : 4;
		for (int i = 0; i < octets; i++) begin
			case ($urandom_range(0, 3))
				0:       v = $urandom_range(0, 9);
				1:       v = $urandom_range(10, 99);
				2:       v = $urandom_range(100, 255);
				default: v = ($urandom_range(0, 1) != 0) ? 255 : 0;
			endcase
			if (i > 0)
				s = {s, "."};
			if ($urandom_range(0, 15) == 0)
				s = {s, "0"};
			s = {s, $sformatf("%0d", v)};
		end
		return text_bytes(s);
	endfunction

	function automatic char_q_t v6_text();
		string s;
		int    groups;
		int    split;
		int    width;
		bit    squeeze;
		s = "";
		squeeze = $urandom_range(0, 1);
		if (squeeze)
			groups = $urandom_range(0, 7);
		else
			groups = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : 8;
		split = $urandom_range(0, groups);
		for (int g = 0; g < groups; g++) begin
			if (squeeze && g == split)
				s = {s, "::"};
			else if (g > 0)
				s = {s, ":"};
			width = ($urandom_range(0, 15) == 0) ? 5 : $urandom_range(1, 4);
			for (int d = 0; d < width; d++)
				s = $sformatf("%s%c", s, pick_from("0123456789abcdefABCDEF"));
		end
		if (squeeze && split == groups)
			s = {s, "::"};
		return text_bytes(s);
	endfunction

	function automatic char_q_t mangle(input char_q_t q);
		int pos;
		pos = $urandom_range(0, q.size() - 1);
		case ($urandom_range(0, 4))
			0: q[pos] = 8'($urandom_range(1, 255));
			1: q.insert(pos, pick_from(".:0aF"));
			2: if (q.size() > 1) q.delete(pos);
			3: q.push_back(CH_COLON);
			default: q.push_front(CH_COLON);
		endcase
		return q;
	endfunction

	function automatic char_q_t noise(input int lo, input int hi, input string set,
			input int wild_pct);
		char_q_t q;
		int      n;
		n = $urandom_range(lo, hi);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < wild_pct)
				q.push_back(8'($urandom_range(1, 255)));
			else
				q.push_back(pick_from(set));
		end
		return q;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("MISMATCH at cycle %0d: %s", cycle_count, what);
	endtask

	task automatic send_text(input char_q_t txt, input int want);
		bit    gappy;
		bit    has;
		bit    fin;
		kind_t k;
		gappy = !calm && short_left == 0 && ($urandom_range(0, 1) != 0);
		for (int i = 0; i < txt.size(); i++) begin
			fin = (i == txt.size() - 1);
			@(negedge clk);
			if (gappy && $urandom_range(0, 3) == 0) begin
				text_bus.valid <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			text_bus.valid <= 1'b1;
			text_bus.ch    <= txt[i];
			text_bus.last  <= fin;
			@(posedge clk);
			while (text_bus.ready !== 1'b1) begin
				stall_cycles++;
				@(posedge clk);
			end
			chars_sent++;
			scan_char(txt[i], fin, has, k);
			if (has)
				verdict_due.push_back((want == PREDICT) ? k : kind_t'(want));
		end
		strings_sent++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d verdicts outstanding",
				cycle_count, verdict_due.size());
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && verdict_bus.valid === 1'b1 && verdict_bus.ready === 1'b1) begin
			if (verdict_due.size() == 0) begin
				report_mismatch($sformatf("verdict %0d with none outstanding",
					verdict_bus.kind));
			end else begin
				next_due = verdict_due.pop_front();
				if (verdict_bus.kind !== next_due)
					report_mismatch($sformatf("kind %0d, expected %s",
						verdict_bus.kind, next_due.name()));
				else
					kind_seen[next_due]++;
			end
		end
	end

	// verdict side: random stall bursts, one long hold-off to back up the input
	initial begin
		int stall_left;
		int mode_left;
		bit stall_mode;
		stall_left = 0;
		mode_left = 0;
		stall_mode = 0;
		verdict_bus.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 1);
				mode_left = $urandom_range(20, 120);
			end else begin
				mode_left--;
			end
			if (choke_req && !choke_done && choke_left == 0)
				choke_left = CHOKE_CYCLES;
			if (choke_left > 0) begin
				verdict_bus.ready <= 1'b0;
				choke_left--;
				if (choke_left == 0)
					choke_done = 1;
			end else if (stall_left > 0) begin
				verdict_bus.ready <= 1'b0;
				stall_left--;
			end else if (stall_mode && !calm && $urandom_range(0, 5) == 0) begin
				verdict_bus.ready <= 1'b0;
				stall_left = $urandom_range(1, 11) - 1;
			end else begin
				verdict_bus.ready <= 1'b1;
			end
		end
	end

	initial begin
		char_q_t txt;
		int      pick;
		text_bus.valid <= 1'b0;
		text_bus.ch    <= CH_ZERO;
		text_bus.last  <= 1'b0;
		scan = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			send_text(text_bytes(dir_text[i]), dir_want[i]);

		while (chars_sent < CHAR_TARGET) begin
			if (!choke_req && chars_sent >= CHOKE_AT) begin
				choke_req = 1;
				short_left = 16;
			end
			calm = (chars_sent >= CALM_AFTER);
			if (short_left > 0) begin
				txt = noise(1, 2, "1.:", 0);
				short_left--;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 25)
					txt = v4_text();
				else if (pick < 50)
					txt = v6_text();
				else if (pick < 62)
					txt = mangle(v4_text());
				else if (pick < 74)
					txt = mangle(v6_text());
				else if (pick < 84)
					txt = noise(1, 12, "0123456789abcdefABCDEFgxz.: ", 25);
				else if (pick < 92)
					txt = noise(2, 10, ":::1aF", 0);
				else if (pick < 96)
					txt = noise(20, 40, "0123456789.:aF", 5);
				else
					txt = noise(1, 15, "0123456789.", 0);
			end
			send_text(txt, PREDICT);
		end
		@(negedge clk);
		text_bus.valid <= 1'b0;

		while (verdict_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d strings (%0d characters, %0d from the directed table).",
			strings_sent, chars_sent, N_DIRECTED);
		$display("Verdicts: %0d none, %0d IPv4, %0d IPv6; %0d input stall cycles, %0d errors.",
			kind_seen[KIND_NONE], kind_seen[KIND_V4], kind_seen[KIND_V6], stall_cycles, errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
src/ipav_pkg.sv
src/ipav_if.sv
src/ip_address_text_validator_core.sv
bench/ip_address_text_validator_core_test.sv
